@@ hdl/chte_pkg.sv @@
package chte_pkg;

    localparam int MAX_BUCKETS   = 1024;
    localparam int BUCKET_DEPTH  = 8;
    localparam int START_BUCKETS = 10;
    localparam int MIN_GROWN     = 10;

    localparam int KEY_W   = 31;
    localparam int VAL_W   = 32;
    localparam int CNT_W   = 14;
    localparam int BKT_W   = 11;
    localparam int BIDX_W  = $clog2(MAX_BUCKETS);
    localparam int SLOT_W  = $clog2(BUCKET_DEPTH);
    localparam int BANK_AW = BIDX_W + SLOT_W;
    localparam int ADDR_W  = BANK_AW + 1;
    localparam int DIV_CW  = $clog2(KEY_W);

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_SEARCH = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_REPLACED  = 3'd1,
        ST_REMOVED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FOUND     = 3'd4,
        ST_FULL      = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_GCLR, S_GRD, S_GCHK, S_GDIV,
        S_DRD, S_DCHK, S_DIV, S_LOOK, S_ACT, S_FIN
    } state_t;

    typedef struct packed {
        logic             used;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

    // floor(n*9/5) via reciprocal multiply, clamped to [MIN_GROWN, MAX_BUCKETS]
    function automatic logic [BKT_W-1:0] grow_count(input logic [BKT_W-1:0] n);
        logic [14:0] prod;
        logic [29:0] scaled;
        logic [13:0] q;
        prod   = 15'(n) * 15'd9;
        scaled = 30'(prod) * 30'd13108;
        q      = scaled[29:16];
        if (q < 14'(MIN_GROWN))
            q = 14'(MIN_GROWN);
        if (q > 14'(MAX_BUCKETS))
            q = 14'(MAX_BUCKETS);
        return q[BKT_W-1:0];
    endfunction

endpackage

@@ hdl/chte_if.sv @@
interface chte_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                kind;
    logic [chte_pkg::KEY_W-1:0] key;
    logic [chte_pkg::VAL_W-1:0] value;
    modport source (output valid, kind, key, value, input ready);
    modport sink   (input valid, kind, key, value, output ready);
endinterface

interface chte_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [2:0]                status;
    logic [chte_pkg::VAL_W-1:0] found_value;
    logic [chte_pkg::CNT_W-1:0] entry_count;
    logic [chte_pkg::BKT_W-1:0] bucket_count;
    logic                      table_empty;
    modport source (output valid, status, found_value, entry_count, bucket_count,
                    table_empty, input ready);
    modport sink   (input valid, status, found_value, entry_count, bucket_count,
                    table_empty, output ready);
endinterface

@@ hdl/chained_hash_table_engine.sv @@
// Channel | Dir | Beat contents
// req     | in  | kind, key, value
// rsp     | out | status, found_value, entry_count, bucket_count, table_empty
//
// Each insert, remove or search beat reduces the key mod bucket_count bit-serially,
// then reads the bucket's slots from the table memory and acts on them.
// An insert that grows the table first clears the other bank, then scans the old
// bank and rehashes every live entry into the new bank; growth is abandoned if a new bucket overflows.
// After reset a clearing pass over both banks runs before req is taken.
// req is taken only when idle; a finished result waits in the rsp register.
module chained_hash_table_engine (
    input  logic          clk,
    input  logic          rst_n,
    chte_req_if.sink      req,
    chte_rsp_if.source    rsp
);

    chte_pkg::state_t state_reg, state_next;
    logic [1:0]                   kind_reg, kind_next;
    logic [chte_pkg::KEY_W-1:0]   key_reg, key_next;
    logic [chte_pkg::VAL_W-1:0]   val_reg, val_next;
    logic                         bank_reg, bank_next;
    logic [chte_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [chte_pkg::BKT_W-1:0]   bkt_reg, bkt_next;
    logic [chte_pkg::BKT_W-1:0]   nbkt_reg, nbkt_next;
    logic [chte_pkg::ADDR_W-1:0]  clr_reg, clr_next;
    logic [chte_pkg::ADDR_W-1:0]  scan_reg, scan_next;
    logic [chte_pkg::SLOT_W-1:0]  dst_reg, dst_next;
    logic [chte_pkg::KEY_W-1:0]   mkey_reg, mkey_next;
    logic [chte_pkg::VAL_W-1:0]   mval_reg, mval_next;
    logic [chte_pkg::KEY_W-1:0]   dnum_reg, dnum_next;
    logic [chte_pkg::BKT_W-1:0]   drem_reg, drem_next;
    logic [chte_pkg::DIV_CW-1:0]  dcnt_reg, dcnt_next;
    logic [chte_pkg::BIDX_W-1:0]  bidx_reg, bidx_next;
    logic [chte_pkg::SLOT_W:0]    slot_reg, slot_next;
    logic                         hit_reg, hit_next;
    logic [chte_pkg::SLOT_W-1:0]  hslot_reg, hslot_next;
    logic [chte_pkg::VAL_W-1:0]   hval_reg, hval_next;
    logic                         free_reg, free_next;
    logic [chte_pkg::SLOT_W-1:0]  fslot_reg, fslot_next;
    logic [2:0]                   stat_reg, stat_next;
    logic [chte_pkg::VAL_W-1:0]   fval_reg, fval_next;

    logic                         ovalid_reg, ovalid_next;
    logic [2:0]                   ostat_reg, ostat_next;
    logic [chte_pkg::VAL_W-1:0]   ofval_reg, ofval_next;
    logic [chte_pkg::CNT_W-1:0]   ocnt_reg, ocnt_next;
    logic [chte_pkg::BKT_W-1:0]   obkt_reg, obkt_next;

    logic                         mem_we;
    logic [chte_pkg::ADDR_W-1:0]  mem_waddr, mem_raddr;
    chte_pkg::entry_t             mem_wdata, rdata_reg;
    chte_pkg::entry_t             mem [2**chte_pkg::ADDR_W];

    logic [chte_pkg::BKT_W-1:0]   div_d;
    logic [chte_pkg::BKT_W:0]     div_sh;
    logic [chte_pkg::BKT_W-1:0]   div_rem;
    logic [chte_pkg::SLOT_W-1:0]  chk_slot;
    logic [16:0]                  load_lhs, load_rhs;
    logic [chte_pkg::BKT_W-1:0]   grown;

    // table memory: one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rdata_reg <= mem[mem_raddr];
    end

    // one restoring remainder step
    always_comb
    begin
        div_d  = (state_reg == chte_pkg::S_GDIV) ? nbkt_reg : bkt_reg;
        div_sh = {drem_reg, dnum_reg[chte_pkg::KEY_W-1]};
        if (div_sh >= {1'b0, div_d})
            div_rem = chte_pkg::BKT_W'(div_sh - {1'b0, div_d});
        else
            div_rem = div_sh[chte_pkg::BKT_W-1:0];
    end

    assign load_lhs = 17'(cnt_reg) * 17'd5 + 17'd5;
    assign load_rhs = 17'(bkt_reg) * 17'd4;
    assign grown    = chte_pkg::grow_count(bkt_reg);
    assign chk_slot = chte_pkg::SLOT_W'(slot_reg - 1'b1);

    // sequencer: next state, memory control and outputs
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        bank_next  = bank_reg;
        cnt_next   = cnt_reg;
        bkt_next   = bkt_reg;
        nbkt_next  = nbkt_reg;
        clr_next   = clr_reg;
        scan_next  = scan_reg;
        dst_next   = dst_reg;
        mkey_next  = mkey_reg;
        mval_next  = mval_reg;
        dnum_next  = dnum_reg;
        drem_next  = drem_reg;
        dcnt_next  = dcnt_reg;
        bidx_next  = bidx_reg;
        slot_next  = slot_reg;
        hit_next   = hit_reg;
        hslot_next = hslot_reg;
        hval_next  = hval_reg;
        free_next  = free_reg;
        fslot_next = fslot_reg;
        stat_next  = stat_reg;
        fval_next  = fval_reg;
        ovalid_next = ovalid_reg;
        ostat_next  = ostat_reg;
        ofval_next  = ofval_reg;
        ocnt_next   = ocnt_reg;
        obkt_next   = obkt_reg;
        mem_we      = 1'b0;
        mem_waddr   = clr_reg;
        mem_wdata   = '0;
        mem_raddr   = {bank_reg, bidx_reg, slot_reg[chte_pkg::SLOT_W-1:0]};
        req.ready   = (state_reg == chte_pkg::S_IDLE);

        // drop the result once taken
        if (rsp.ready)
            ovalid_next = 1'b0;

        case (state_reg)
            chte_pkg::S_CLR:
            begin
                mem_we = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (&clr_reg)
                    state_next = chte_pkg::S_IDLE;
            end
            chte_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    kind_next = req.kind;
                    key_next  = req.key;
                    val_next  = req.value;
                    dnum_next = req.key;
                    drem_next = '0;
                    dcnt_next = '0;
                    stat_next = chte_pkg::ST_NOT_FOUND;
                    fval_next = '0;
                    if (req.kind == chte_pkg::KIND_NONE)
                        state_next = chte_pkg::S_FIN;
                    else if (req.kind == chte_pkg::KIND_INSERT && load_lhs > load_rhs
                             && grown != bkt_reg)
                    begin
                        nbkt_next  = grown;
                        clr_next   = '0;
                        state_next = chte_pkg::S_GCLR;
                    end
                    else
                        state_next = chte_pkg::S_DIV;
                end
            end
            chte_pkg::S_GCLR:
            begin
                // clear the used marks of the other bank
                mem_we    = 1'b1;
                mem_waddr = {~bank_reg, clr_reg[chte_pkg::BANK_AW-1:0]};
                clr_next  = clr_reg + 1'b1;
                if (&clr_reg[chte_pkg::BANK_AW-1:0])
                begin
                    scan_next  = '0;
                    state_next = chte_pkg::S_GRD;
                end
            end
            chte_pkg::S_GRD:
            begin
                mem_raddr = {bank_reg, scan_reg[chte_pkg::BANK_AW-1:0]};
                if (scan_reg[chte_pkg::ADDR_W-1:chte_pkg::SLOT_W] == bkt_reg)
                begin
                    // rehash done: switch banks, hash the request key again
                    bank_next  = ~bank_reg;
                    bkt_next   = nbkt_reg;
                    dnum_next  = key_reg;
                    drem_next  = '0;
                    dcnt_next  = '0;
                    state_next = chte_pkg::S_DIV;
                end
                else
                    state_next = chte_pkg::S_GCHK;
            end
            chte_pkg::S_GCHK:
            begin
                if (!rdata_reg.used)
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = chte_pkg::S_GRD;
                end
                else
                begin
                    mkey_next  = rdata_reg.key;
                    mval_next  = rdata_reg.value;
                    dnum_next  = rdata_reg.key;
                    drem_next  = '0;
                    dcnt_next  = '0;
                    state_next = chte_pkg::S_GDIV;
                end
            end
            chte_pkg::S_GDIV, chte_pkg::S_DIV:
            begin
                dnum_next = {dnum_reg[chte_pkg::KEY_W-2:0], 1'b0};
                drem_next = div_rem;
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == chte_pkg::DIV_CW'(chte_pkg::KEY_W - 1))
                begin
                    bidx_next = div_rem[chte_pkg::BIDX_W-1:0];
                    if (state_reg == chte_pkg::S_GDIV)
                    begin
                        dst_next   = '0;
                        state_next = chte_pkg::S_DRD;
                    end
                    else
                    begin
                        slot_next  = '0;
                        hit_next   = 1'b0;
                        free_next  = 1'b0;
                        state_next = chte_pkg::S_LOOK;
                    end
                end
            end
            chte_pkg::S_DRD:
            begin
                mem_raddr  = {~bank_reg, bidx_reg, dst_reg};
                state_next = chte_pkg::S_DCHK;
            end
            chte_pkg::S_DCHK:
            begin
                if (!rdata_reg.used)
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = {~bank_reg, bidx_reg, dst_reg};
                    mem_wdata  = '{used: 1'b1, key: mkey_reg, value: mval_reg};
                    scan_next  = scan_reg + 1'b1;
                    state_next = chte_pkg::S_GRD;
                end
                else if (dst_reg == chte_pkg::SLOT_W'(chte_pkg::BUCKET_DEPTH - 1))
                begin
                    // new bucket overflows: abandon growth, use old table
                    dnum_next  = key_reg;
                    drem_next  = '0;
                    dcnt_next  = '0;
                    state_next = chte_pkg::S_DIV;
                end
                else
                begin
                    dst_next   = dst_reg + 1'b1;
                    state_next = chte_pkg::S_DRD;
                end
            end
            chte_pkg::S_LOOK:
            begin
                // issue slot reads, check the previous slot's data
                slot_next = slot_reg + 1'b1;
                if (slot_reg != '0)
                begin
                    if (rdata_reg.used)
                    begin
                        if (!hit_reg && rdata_reg.key == key_reg)
                        begin
                            hit_next   = 1'b1;
                            hslot_next = chk_slot;
                            hval_next  = rdata_reg.value;
                        end
                    end
                    else if (!free_reg)
                    begin
                        free_next  = 1'b1;
                        fslot_next = chk_slot;
                    end
                end
                if (slot_reg == (chte_pkg::SLOT_W+1)'(chte_pkg::BUCKET_DEPTH))
                    state_next = chte_pkg::S_ACT;
            end
            chte_pkg::S_ACT:
            begin
                state_next = chte_pkg::S_FIN;
                mem_waddr  = {bank_reg, bidx_reg, hslot_reg};
                case (kind_reg)
                    chte_pkg::KIND_INSERT:
                    begin
                        mem_wdata = '{used: 1'b1, key: key_reg, value: val_reg};
                        if (hit_reg)
                        begin
                            mem_we    = 1'b1;
                            stat_next = chte_pkg::ST_REPLACED;
                        end
                        else if (free_reg)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = {bank_reg, bidx_reg, fslot_reg};
                            cnt_next  = cnt_reg + 1'b1;
                            stat_next = chte_pkg::ST_INSERTED;
                        end
                        else
                            stat_next = chte_pkg::ST_FULL;
                    end
                    chte_pkg::KIND_REMOVE:
                    begin
                        if (hit_reg)
                        begin
                            mem_we    = 1'b1;
                            if (cnt_reg != '0)
                                cnt_next = cnt_reg - 1'b1;
                            stat_next = chte_pkg::ST_REMOVED;
                        end
                    end
                    chte_pkg::KIND_SEARCH:
                    begin
                        if (hit_reg)
                        begin
                            fval_next = hval_reg;
                            stat_next = chte_pkg::ST_FOUND;
                        end
                    end
                    default:
                    begin
                        stat_next = chte_pkg::ST_NOT_FOUND;
                    end
                endcase
            end
            chte_pkg::S_FIN:
            begin
                // hold until the result register is free
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = stat_reg;
                    ofval_next  = fval_reg;
                    ocnt_next   = cnt_reg;
                    obkt_next   = bkt_reg;
                    state_next  = chte_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = chte_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= chte_pkg::S_CLR;
            bank_reg   <= 1'b0;
            cnt_reg    <= '0;
            bkt_reg    <= chte_pkg::BKT_W'(chte_pkg::START_BUCKETS);
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            bank_reg   <= bank_next;
            cnt_reg    <= cnt_next;
            bkt_reg    <= bkt_next;
            clr_reg    <= clr_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        key_reg   <= key_next;
        val_reg   <= val_next;
        nbkt_reg  <= nbkt_next;
        scan_reg  <= scan_next;
        dst_reg   <= dst_next;
        mkey_reg  <= mkey_next;
        mval_reg  <= mval_next;
        dnum_reg  <= dnum_next;
        drem_reg  <= drem_next;
        dcnt_reg  <= dcnt_next;
        bidx_reg  <= bidx_next;
        slot_reg  <= slot_next;
        hit_reg   <= hit_next;
        hslot_reg <= hslot_next;
        hval_reg  <= hval_next;
        free_reg  <= free_next;
        fslot_reg <= fslot_next;
        stat_reg  <= stat_next;
        fval_reg  <= fval_next;
        ostat_reg <= ostat_next;
        ofval_reg <= ofval_next;
        ocnt_reg  <= ocnt_next;
        obkt_reg  <= obkt_next;
    end

    assign rsp.valid        = ovalid_reg;
    assign rsp.status       = ostat_reg;
    assign rsp.found_value  = ofval_reg;
    assign rsp.entry_count  = ocnt_reg;
    assign rsp.bucket_count = obkt_reg;
    assign rsp.table_empty  = (ocnt_reg == '0);

    a_bkt_range: assert property (@(posedge clk) disable iff (!rst_n)
        bkt_reg >= chte_pkg::BKT_W'(chte_pkg::MIN_GROWN)
        && bkt_reg <= chte_pkg::BKT_W'(chte_pkg::MAX_BUCKETS))
        else $error("bucket count out of range");

    a_clear_writes_unused: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == chte_pkg::S_CLR || state_reg == chte_pkg::S_GCLR)
        |-> (mem_we && !mem_wdata.used))
        else $error("clearing pass wrote a used slot");

    a_insert_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == chte_pkg::S_ACT && kind_reg == chte_pkg::KIND_INSERT
         && !hit_reg && free_reg) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("new insert did not bump the entry count");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> state_reg != chte_pkg::S_IDLE)
        else $error("accepted beat left the sequencer idle");

endmodule

@@ verif/chte_checker.sv @@
module chte_checker (
    input  logic clk,
    input  logic rst_n,
    chte_req_if  req,
    chte_rsp_if  rsp,
    output int   mismatches,
    output int   outstanding,
    output int   results_seen,
    output int   growths_seen,
    output int   full_seen
);

    localparam int BANK_SLOTS = chte_pkg::MAX_BUCKETS * chte_pkg::BUCKET_DEPTH;

    typedef struct packed {
        logic [2:0]                 status;
        logic [chte_pkg::VAL_W-1:0] found_value;
        logic [chte_pkg::CNT_W-1:0] entry_count;
        logic [chte_pkg::BKT_W-1:0] bucket_count;
        logic                       table_empty;
    } outcome_t;

    // Shadow copy of the table
    bit                       shadow_used [2*BANK_SLOTS];
    bit [chte_pkg::KEY_W-1:0] shadow_key  [2*BANK_SLOTS];
    bit [chte_pkg::VAL_W-1:0] shadow_val  [2*BANK_SLOTS];
    bit             cur_bank;
    int unsigned    live_entries;
    int unsigned    live_buckets;

    outcome_t expected_outcomes [$];

    function automatic int slot_index(bit bank, int unsigned bucket, int s);
        return (int'(bank) * chte_pkg::MAX_BUCKETS + int'(bucket)) * chte_pkg::BUCKET_DEPTH + s;
    endfunction

    // Rehash every live entry into the other bank; abandon on overflow
    function automatic void grow_table();
        int unsigned old_n;
        int unsigned new_n;
        bit          other;
        int unsigned nb;
        int          src;
        int          dst;
        bit          placed;
        old_n = live_buckets;
        new_n = (old_n * 9) / 5;
        other = ~cur_bank;
        if (new_n < chte_pkg::MIN_GROWN)
            new_n = chte_pkg::MIN_GROWN;
        if (new_n > chte_pkg::MAX_BUCKETS)
            new_n = chte_pkg::MAX_BUCKETS;
        if (new_n == old_n)
            return;
        for (int i = 0; i < BANK_SLOTS; i++)
            shadow_used[slot_index(other, 0, 0) + i] = 0;
        for (int b = 0; b < old_n; b++)
        begin
            for (int s = 0; s < chte_pkg::BUCKET_DEPTH; s++)
            begin
                src = slot_index(cur_bank, b, s);
                if (!shadow_used[src])
                    continue;
                nb = shadow_key[src] % new_n;
                placed = 0;
                for (int t = 0; t < chte_pkg::BUCKET_DEPTH; t++)
                begin
                    dst = slot_index(other, nb, t);
                    if (!shadow_used[dst])
                    begin
                        shadow_used[dst] = 1;
                        shadow_key[dst] = shadow_key[src];
                        shadow_val[dst] = shadow_val[src];
                        placed = 1;
                        break;
                    end
                end
                if (!placed)
                    return;
            end
        end
        cur_bank = other;
        live_buckets = new_n;
        growths_seen++;
    endfunction

    function automatic outcome_t apply_table_op(logic [1:0] kind,
                                                logic [chte_pkg::KEY_W-1:0] key,
                                                logic [chte_pkg::VAL_W-1:0] value);
        outcome_t    o;
        int unsigned bucket;
        int          hit;
        int          free_slot;
        int          i;
        o = '0;
        o.status = chte_pkg::ST_NOT_FOUND;
        hit = -1;
        free_slot = -1;
        if (kind == chte_pkg::KIND_INSERT && 5 * (live_entries + 1) > 4 * live_buckets)
            grow_table();
        if (kind != chte_pkg::KIND_NONE)
        begin
            bucket = key % live_buckets;
            for (int s = 0; s < chte_pkg::BUCKET_DEPTH; s++)
            begin
                i = slot_index(cur_bank, bucket, s);
                if (shadow_used[i])
                begin
                    if (hit < 0 && shadow_key[i] == key)
                        hit = s;
                end
                else if (free_slot < 0)
                    free_slot = s;
            end
            case (kind)
                chte_pkg::KIND_INSERT:
                begin
                    if (hit >= 0)
                    begin
                        shadow_val[slot_index(cur_bank, bucket, hit)] = value;
                        o.status = chte_pkg::ST_REPLACED;
                    end
                    else if (free_slot >= 0)
                    begin
                        i = slot_index(cur_bank, bucket, free_slot);
                        shadow_used[i] = 1;
                        shadow_key[i] = key;
                        shadow_val[i] = value;
                        live_entries++;
                        o.status = chte_pkg::ST_INSERTED;
                    end
                    else
                    begin
                        o.status = chte_pkg::ST_FULL;
                        full_seen++;
                    end
                end
                chte_pkg::KIND_REMOVE:
                begin
                    if (hit >= 0)
                    begin
                        shadow_used[slot_index(cur_bank, bucket, hit)] = 0;
                        if (live_entries > 0)
                            live_entries--;
                        o.status = chte_pkg::ST_REMOVED;
                    end
                end
                default:
                begin
                    if (hit >= 0)
                    begin
                        o.found_value = shadow_val[slot_index(cur_bank, bucket, hit)];
                        o.status = chte_pkg::ST_FOUND;
                    end
                end
            endcase
        end
        o.entry_count = live_entries[chte_pkg::CNT_W-1:0];
        o.bucket_count = live_buckets[chte_pkg::BKT_W-1:0];
        o.table_empty = (live_entries == 0);
        return o;
    endfunction

    assign outstanding = expected_outcomes.size();

    // Predict on every request beat, compare on every response beat
    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        outcome_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < 2*BANK_SLOTS; i++)
                shadow_used[i] = 0;
            cur_bank = 0;
            live_entries = 0;
            live_buckets = chte_pkg::START_BUCKETS;
            expected_outcomes.delete();
            mismatches = 0;
            results_seen = 0;
            growths_seen = 0;
            full_seen = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                got = {rsp.status, rsp.found_value, rsp.entry_count, rsp.bucket_count,
                       rsp.table_empty};
                results_seen++;
                if (expected_outcomes.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response beat: %p", got);
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p, got %p", want, got);
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                want = apply_table_op(req.kind, req.key, req.value);
                expected_outcomes = {expected_outcomes, want};
            end
        end
    end

endmodule

@@ verif/testbench.sv @@
module testbench;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    int   results_seen;
    int   growths_seen;
    int   full_seen;
    int   src_idle_pct;
    int   snk_idle_pct;
    int   hold_request;
    int   hold_left;
    int   beats_sent;

    logic [chte_pkg::KEY_W-1:0] recent_keys [64];

    chte_req_if req ();
    chte_rsp_if rsp ();

    chained_hash_table_engine u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    chte_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .rsp          (rsp),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .growths_seen (growths_seen),
        .full_seen    (full_seen)
    );

    initial
    begin
        clk = 0;
    end

    always #5 clk = ~clk;

    // Drive the response ready, with one long hold-off
    initial
    begin
        rsp.ready <= 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 0;
            end
            else
                rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Offer one beat; ready is sampled mid-cycle to stay clear of edge races
    task automatic send_beat(logic [1:0] kind, logic [chte_pkg::KEY_W-1:0] key,
                             logic [chte_pkg::VAL_W-1:0] value);
        bit took;
        while ($urandom_range(99) < src_idle_pct)
        begin
            req.valid <= 0;
            @(posedge clk);
        end
        req.valid <= 1;
        req.kind <= kind;
        req.key <= key;
        req.value <= value;
        do
        begin
            @(negedge clk);
            took = req.ready;
            @(posedge clk);
        end
        while (!took);
        beats_sent++;
    endtask

    task automatic send_random_beat();
        int                         roll;
        logic [1:0]                 kind;
        logic [chte_pkg::KEY_W-1:0] key;
        roll = $urandom_range(99);
        if (roll < 45)
            kind = chte_pkg::KIND_INSERT;
        else if (roll < 67)
            kind = chte_pkg::KIND_REMOVE;
        else if (roll < 95)
            kind = chte_pkg::KIND_SEARCH;
        else
            kind = chte_pkg::KIND_NONE;
        roll = $urandom_range(99);
        if (roll < 55)
            key = recent_keys[$urandom_range(63)];
        else if (roll < 75)
            key = chte_pkg::KEY_W'($urandom_range(40) * 1440);
        else
            key = chte_pkg::KEY_W'($urandom);
        if (kind == chte_pkg::KIND_INSERT)
            recent_keys[$urandom_range(63)] = key;
        send_beat(kind, key, $urandom);
    endtask

    initial
    begin
        rst_n = 0;
        req.valid <= 0;
        req.kind <= chte_pkg::KIND_INSERT;
        req.key <= '0;
        req.value <= '0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_request = 0;
        beats_sent = 0;
        for (int i = 0; i < 64; i++)
            recent_keys[i] = chte_pkg::KEY_W'($urandom);
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: empty table, unused kind, extreme keys and values, replace, remove
        send_beat(chte_pkg::KIND_SEARCH, '0, '1);
        send_beat(chte_pkg::KIND_REMOVE, '0, '0);
        send_beat(chte_pkg::KIND_NONE, '1, '1);
        send_beat(chte_pkg::KIND_INSERT, '1, '1);
        send_beat(chte_pkg::KIND_INSERT, '0, '0);
        send_beat(chte_pkg::KIND_INSERT, '1, 32'h5A5A_A5A5);
        send_beat(chte_pkg::KIND_SEARCH, '1, '0);
        send_beat(chte_pkg::KIND_REMOVE, '0, '0);
        send_beat(chte_pkg::KIND_REMOVE, '0, '0);
        send_beat(chte_pkg::KIND_SEARCH, '0, '0);
        send_beat(chte_pkg::KIND_REMOVE, '1, '0);
        // Colliding keys survive the first growth together, then overflow the bucket
        for (int i = 1; i <= 10; i++)
            send_beat(chte_pkg::KIND_INSERT, chte_pkg::KEY_W'(i * 90), 32'(i));
        send_beat(chte_pkg::KIND_SEARCH, chte_pkg::KEY_W'(450), '0);
        req.valid <= 0;

        // Hold the sender until the table has answered everything
        while (outstanding != 0)
            @(posedge clk);

        // Phase one: sender idles lightly, receiver heavily, with a long stall
        src_idle_pct = 28;
        snk_idle_pct = 66;
        hold_request = 400;
        for (int i = 0; i < 415; i++)
            send_random_beat();

        // Phase two: roles swapped
        src_idle_pct = 66;
        snk_idle_pct = 28;
        for (int i = 0; i < 415; i++)
            send_random_beat();

        // Phase three: full rate both ways
        src_idle_pct = 0;
        snk_idle_pct = 0;
        for (int i = 0; i < 415; i++)
            send_random_beat();
        req.valid <= 0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("covered %0d request beats, %0d responses, %0d table growths, %0d full buckets",
                 beats_sent, results_seen, growths_seen, full_seen);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Bound the run
    initial
    begin
        #30000000;
        $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/chte_pkg.sv
hdl/chte_if.sv
hdl/chained_hash_table_engine.sv
verif/chte_checker.sv
verif/testbench.sv
